// ===== rtl/core/arp_pkg.sv =====
// shared constants, codes and control types for the arp table resolver
`default_nettype none

package arp_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int CMD_W      = 2;
    localparam int EV_W       = 2;
    localparam int ST_W       = 3;
    localparam int ENTRY_W    = 6;
    localparam int TO_W       = 20;
    localparam int ATT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int MSEL_W     = 2;

    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [EV_W-1:0] EV_LOOKUP  = 2'd0;
    localparam logic [EV_W-1:0] EV_REQUEST = 2'd1;
    localparam logic [EV_W-1:0] EV_UPDATE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_LINKDOWN = 3'd3;
    localparam logic [ST_W-1:0] ST_NOREPLY  = 3'd4;
    localparam logic [ST_W-1:0] ST_BUSY     = 3'd5;
    localparam logic [ST_W-1:0] ST_NONE     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPTS = 2'd1;

    localparam logic [TO_W-1:0]  TIMEOUT_RST  = 20'h1FFFF;
    localparam logic [ATT_W-1:0] ATTEMPTS_RST = 3'd3;

    localparam logic [MSEL_W-1:0] MAC_ZERO = 2'd0;
    localparam logic [MSEL_W-1:0] MAC_READ = 2'd1;
    localparam logic [MSEL_W-1:0] MAC_CAP  = 2'd2;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [ST_W-1:0]   st;
        logic [MSEL_W-1:0] mac_sel;
        logic              ip_pend;
        logic              last;
    } arp_res_t;

    typedef struct packed {
        logic     cap;
        logic     srch_start;
        logic     srch_go;
        logic     append;
        logic     pend_set;
        logic     pend_clr;
        logic     tick_dec;
        logic     retry;
        logic     res_load;
        arp_res_t res;
    } arp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pending;
        logic             pend_match;
        logic             link;
        logic             hit;
        logic             miss;
        logic             expire;
        logic             att_zero;
        logic             out_free;
    } arp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/arp_dp.sv =====
// datapath: table memory, search pointer, pending timer, config and output registers
`default_nettype none

module arp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [arp_pkg::CMD_W-1:0]     command,
    input  wire logic [arp_pkg::IP_W-1:0]      in_ip,
    input  wire logic [arp_pkg::MAC_W-1:0]     in_mac,
    input  wire logic                          link_up,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [arp_pkg::EV_W-1:0]           event_res,
    output logic [arp_pkg::ST_W-1:0]           status,
    output logic [arp_pkg::IP_W-1:0]           out_ip,
    output logic [arp_pkg::MAC_W-1:0]          out_mac,
    output logic [arp_pkg::ENTRY_W-1:0]        entry_count,
    output logic                               last,
    input  wire arp_pkg::arp_cmd_t             cmd,
    output arp_pkg::arp_sts_t                  sts
);

    logic [arp_pkg::TO_W-1:0]  timeout_reg;
    logic [arp_pkg::ATT_W-1:0] attempts_reg;

    logic [arp_pkg::CMD_W-1:0] cap_cmd_reg;
    logic [arp_pkg::IP_W-1:0]  cap_ip_reg;
    logic [arp_pkg::MAC_W-1:0] cap_mac_reg;
    logic                      cap_link_reg;

    logic [arp_pkg::CNT_W-1:0] used_reg, used_next;
    logic                      pending_reg, pending_next;
    logic [arp_pkg::IP_W-1:0]  pend_ip_reg, pend_ip_next;
    logic [arp_pkg::ATT_W-1:0] att_left_reg, att_left_next;
    logic [arp_pkg::TO_W-1:0]  wait_reg, wait_next;

    logic [arp_pkg::CNT_W-1:0] srch_addr_reg, srch_addr_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic [arp_pkg::IP_W-1:0]  rd_ip_reg;
    logic [arp_pkg::MAC_W-1:0] rd_mac_reg;

    logic [arp_pkg::IP_W-1:0]  ip_mem  [arp_pkg::TABLE_DEPTH];
    logic [arp_pkg::MAC_W-1:0] mac_mem [arp_pkg::TABLE_DEPTH];

    logic                         out_valid_reg, out_valid_next;
    logic [arp_pkg::EV_W-1:0]     out_ev_reg;
    logic [arp_pkg::ST_W-1:0]     out_st_reg;
    logic [arp_pkg::IP_W-1:0]     out_ip_reg;
    logic [arp_pkg::MAC_W-1:0]    out_mac_reg;
    logic [arp_pkg::ENTRY_W-1:0]  out_cnt_reg;
    logic                         out_last_reg;

    logic [arp_pkg::TO_W-1:0]  eff_to;
    logic [arp_pkg::ATT_W-1:0] att_init;
    logic [arp_pkg::TO_W-1:0]  wait_dec;
    logic                      hit;
    logic                      more;
    logic                      issue;
    logic                      out_free;
    logic [arp_pkg::IP_W-1:0]  res_ip;
    logic [arp_pkg::MAC_W-1:0] res_mac;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= arp_pkg::TIMEOUT_RST;
            attempts_reg <= arp_pkg::ATTEMPTS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                arp_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_data[arp_pkg::TO_W-1:0];
                arp_pkg::CFG_ATTEMPTS: attempts_reg <= cfg_data[arp_pkg::ATT_W-1:0];
                default:               ;
            endcase
        end
    end

    // captured input beat
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            cap_cmd_reg  <= command;
            cap_ip_reg   <= in_ip;
            cap_mac_reg  <= in_mac;
            cap_link_reg <= link_up;
        end
    end

    assign eff_to   = (timeout_reg == '0) ? arp_pkg::TO_W'(1) : timeout_reg;
    assign att_init = (attempts_reg == '0) ? '0 : attempts_reg - arp_pkg::ATT_W'(1);
    assign wait_dec = (wait_reg != '0) ? wait_reg - arp_pkg::TO_W'(1) : '0;

    always_comb
    begin
        used_next     = used_reg;
        pending_next  = pending_reg;
        pend_ip_next  = pend_ip_reg;
        att_left_next = att_left_reg;
        wait_next     = wait_reg;
        if (cmd.append)
        begin
            used_next = used_reg + arp_pkg::CNT_W'(1);
        end
        if (cmd.pend_set)
        begin
            pending_next  = 1'b1;
            pend_ip_next  = cap_ip_reg;
            att_left_next = att_init;
            wait_next     = eff_to;
        end
        if (cmd.pend_clr)
        begin
            pending_next  = 1'b0;
            att_left_next = '0;
            wait_next     = '0;
        end
        if (cmd.tick_dec)
        begin
            wait_next = wait_dec;
        end
        if (cmd.retry)
        begin
            att_left_next = att_left_reg - arp_pkg::ATT_W'(1);
            wait_next     = eff_to;
        end
    end

    // sequential search, one table read per cycle
    assign hit   = rd_valid_reg && (rd_ip_reg == cap_ip_reg);
    assign more  = srch_addr_reg < used_reg;
    assign issue = cmd.srch_go && !hit && more;

    always_comb
    begin
        srch_addr_next = srch_addr_reg;
        rd_valid_next  = rd_valid_reg;
        if (cmd.srch_start)
        begin
            srch_addr_next = '0;
            rd_valid_next  = 1'b0;
        end
        else if (cmd.srch_go)
        begin
            rd_valid_next = issue;
            if (issue)
            begin
                srch_addr_next = srch_addr_reg + arp_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            ip_mem[used_reg[arp_pkg::AW-1:0]]  <= cap_ip_reg;
            mac_mem[used_reg[arp_pkg::AW-1:0]] <= cap_mac_reg;
        end
        if (issue)
        begin
            rd_ip_reg  <= ip_mem[srch_addr_reg[arp_pkg::AW-1:0]];
            rd_mac_reg <= mac_mem[srch_addr_reg[arp_pkg::AW-1:0]];
        end
    end

    // result beat register
    assign out_free = !out_valid_reg || !out_stall;
    assign res_ip   = cmd.res.ip_pend ? pend_ip_reg : cap_ip_reg;

    always_comb
    begin
        case (cmd.res.mac_sel)
            arp_pkg::MAC_READ: res_mac = rd_mac_reg;
            arp_pkg::MAC_CAP:  res_mac = cap_mac_reg;
            default:           res_mac = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_ev_reg   <= cmd.res.ev;
            out_st_reg   <= cmd.res.st;
            out_ip_reg   <= res_ip;
            out_mac_reg  <= res_mac;
            out_cnt_reg  <= arp_pkg::ENTRY_W'(used_reg);
            out_last_reg <= cmd.res.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            pending_reg   <= 1'b0;
            pend_ip_reg   <= '0;
            att_left_reg  <= '0;
            wait_reg      <= '0;
            srch_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            pending_reg   <= pending_next;
            pend_ip_reg   <= pend_ip_next;
            att_left_reg  <= att_left_next;
            wait_reg      <= wait_next;
            srch_addr_reg <= srch_addr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = out_ev_reg;
    assign status      = out_st_reg;
    assign out_ip      = out_ip_reg;
    assign out_mac     = out_mac_reg;
    assign entry_count = out_cnt_reg;
    assign last        = out_last_reg;

    assign sts.cmd        = cap_cmd_reg;
    assign sts.full       = (used_reg == arp_pkg::CNT_W'(arp_pkg::TABLE_DEPTH));
    assign sts.pending    = pending_reg;
    assign sts.pend_match = (pend_ip_reg == cap_ip_reg);
    assign sts.link       = cap_link_reg;
    assign sts.hit        = hit;
    assign sts.miss       = !rd_valid_reg && !more;
    assign sts.expire     = pending_reg && (wait_dec == '0);
    assign sts.att_zero   = (att_left_reg == '0);
    assign sts.out_free   = out_free;

endmodule

`default_nettype wire

// ===== rtl/core/arp_ctrl.sv =====
// controller: sequences capture, search, table and timer updates and result beats
`default_nettype none

module arp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire arp_pkg::arp_sts_t sts,
    output arp_pkg::arp_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_RES1   = 3'd3;
    localparam logic [2:0] S_RES2   = 3'd4;

    localparam arp_pkg::arp_res_t RES_RESOLVED = '{
        ev: arp_pkg::EV_LOOKUP, st: arp_pkg::ST_OK, mac_sel: arp_pkg::MAC_CAP,
        ip_pend: 1'b0, last: 1'b1};

    logic [2:0]        state_reg, state_next;
    arp_pkg::arp_res_t res1_reg, res1_next;
    logic              two_reg, two_next;

    always_comb
    begin
        state_next = state_reg;
        res1_next  = res1_reg;
        two_next   = two_reg;
        cmd        = '0;
        cmd.res    = res1_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                two_next = 1'b0;
                case (sts.cmd)
                    arp_pkg::CMD_UPDATE:
                    begin
                        if (sts.full)
                        begin
                            res1_next = '{ev: arp_pkg::EV_UPDATE, st: arp_pkg::ST_FULL,
                                          mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0,
                                          last: 1'b1};
                            state_next = S_RES1;
                        end
                        else
                        begin
                            cmd.srch_start = 1'b1;
                            state_next     = S_SEARCH;
                        end
                    end
                    arp_pkg::CMD_LOOKUP:
                    begin
                        cmd.srch_start = 1'b1;
                        state_next     = S_SEARCH;
                    end
                    arp_pkg::CMD_TICK:
                    begin
                        state_next = S_IDLE;
                        if (sts.pending)
                        begin
                            if (!sts.expire)
                            begin
                                cmd.tick_dec = 1'b1;
                            end
                            else if (sts.att_zero)
                            begin
                                cmd.pend_clr = 1'b1;
                                res1_next = '{ev: arp_pkg::EV_LOOKUP, st: arp_pkg::ST_NOREPLY,
                                              mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b1,
                                              last: 1'b1};
                                state_next = S_RES1;
                            end
                            else
                            begin
                                cmd.retry = 1'b1;
                                res1_next = '{ev: arp_pkg::EV_REQUEST, st: arp_pkg::ST_NONE,
                                              mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b1,
                                              last: 1'b1};
                                state_next = S_RES1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                cmd.srch_go = 1'b1;
                if (sts.hit)
                begin
                    if (sts.cmd == arp_pkg::CMD_UPDATE)
                    begin
                        res1_next = '{ev: arp_pkg::EV_UPDATE, st: arp_pkg::ST_PRESENT,
                                      mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        res1_next = '{ev: arp_pkg::EV_LOOKUP, st: arp_pkg::ST_OK,
                                      mac_sel: arp_pkg::MAC_READ, ip_pend: 1'b0, last: 1'b1};
                    end
                    state_next = S_RES1;
                end
                else if (sts.miss)
                begin
                    state_next = S_RES1;
                    if (sts.cmd == arp_pkg::CMD_UPDATE)
                    begin
                        cmd.append = 1'b1;
                        res1_next = '{ev: arp_pkg::EV_UPDATE, st: arp_pkg::ST_OK,
                                      mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0, last: 1'b1};
                        if (sts.pending && sts.pend_match)
                        begin
                            cmd.pend_clr   = 1'b1;
                            two_next       = 1'b1;
                            res1_next.last = 1'b0;
                        end
                    end
                    else if (sts.pending)
                    begin
                        res1_next = '{ev: arp_pkg::EV_LOOKUP, st: arp_pkg::ST_BUSY,
                                      mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0, last: 1'b1};
                    end
                    else if (!sts.link)
                    begin
                        res1_next = '{ev: arp_pkg::EV_LOOKUP, st: arp_pkg::ST_LINKDOWN,
                                      mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0, last: 1'b1};
                    end
                    else
                    begin
                        cmd.pend_set = 1'b1;
                        res1_next = '{ev: arp_pkg::EV_REQUEST, st: arp_pkg::ST_NONE,
                                      mac_sel: arp_pkg::MAC_ZERO, ip_pend: 1'b0, last: 1'b1};
                    end
                end
            end
            S_RES1:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = two_reg ? S_RES2 : S_IDLE;
                end
            end
            S_RES2:
            begin
                cmd.res = RES_RESOLVED;
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res1_reg  <= '0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res1_reg  <= res1_next;
            two_reg   <= two_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/arp_table_resolver.sv =====
// top level of the arp table resolver: controller plus datapath
// One beat is taken at a time. An update or a lookup walks the table one entry per
// cycle through the single read port of the table memory, and stops early when it
// hits. An update to a full table skips the walk. An update that resolves the pending
// lookup loads a second beat after its first. A tick produces a beat only when its
// wait runs out, and an unknown command produces none. A beat that is ready is not
// loaded while the output register is still held.
// The next beat is accepted while a result still waits on the output register.
// The table starts empty at reset and is only read below its fill count, so it
// needs no clearing pass.
`default_nettype none

module arp_table_resolver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [arp_pkg::CMD_W-1:0]      command,
    input  wire logic [arp_pkg::IP_W-1:0]       in_ip,
    input  wire logic [arp_pkg::MAC_W-1:0]      in_mac,
    input  wire logic                           link_up,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [arp_pkg::EV_W-1:0]            event_res,
    output logic [arp_pkg::ST_W-1:0]            status,
    output logic [arp_pkg::IP_W-1:0]            out_ip,
    output logic [arp_pkg::MAC_W-1:0]           out_mac,
    output logic [arp_pkg::ENTRY_W-1:0]         entry_count,
    output logic                                last
);

    arp_pkg::arp_cmd_t cmd;
    arp_pkg::arp_sts_t sts;

    arp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    arp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .in_ip       (in_ip),
        .in_mac      (in_mac),
        .link_up     (link_up),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .status      (status),
        .out_ip      (out_ip),
        .out_mac     (out_mac),
        .entry_count (entry_count),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the arp table resolver: random and directed beats vs a predictor
`timescale 1ns / 1ps

module tb_top;
    import arp_pkg::*;

    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE      = 48;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;

    localparam logic [CMD_W-1:0]     CMD_UNKNOWN  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             link;
    } arp_cmd_beat_t;

    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic [ST_W-1:0]    st;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [ENTRY_W-1:0] cnt;
        logic               last;
    } arp_result_t;

    typedef struct packed {
        logic [TABLE_DEPTH-1:0][IP_W-1:0]  ips;
        logic [TABLE_DEPTH-1:0][MAC_W-1:0] macs;
        logic [ENTRY_W-1:0]                used;
        logic                              pend;
        logic [IP_W-1:0]                   pend_ip;
        logic [ATT_W-1:0]                  att_left;
        logic [TO_W-1:0]                   wait_cnt;
        logic [TO_W-1:0]                   timeout;
        logic [ATT_W-1:0]                  attempts;
    } arp_table_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      command   = '0;
    logic [IP_W-1:0]       in_ip     = '0;
    logic [MAC_W-1:0]      in_mac    = '0;
    logic                  link_up   = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [EV_W-1:0]       event_res;
    logic [ST_W-1:0]       status;
    logic [IP_W-1:0]       out_ip;
    logic [MAC_W-1:0]      out_mac;
    logic [ENTRY_W-1:0]    entry_count;
    logic                  last;

    arp_cmd_beat_t cmd_backlog [$];
    arp_result_t   due_results [$];
    arp_table_t    mirror;
    arp_table_t    plan;
    arp_cmd_beat_t cur_cmd;
    int            n_pushed    = 0;
    int            n_taken     = 0;
    int            n_results   = 0;
    int            n_err       = 0;
    int            hold_left   = 0;
    bit            held        = 1'b0;
    int            quiet_cycles = 0;

    arp_table_resolver u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .in_ip       (in_ip),
        .in_mac      (in_mac),
        .link_up     (link_up),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .status      (status),
        .out_ip      (out_ip),
        .out_mac     (out_mac),
        .entry_count (entry_count),
        .last        (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic arp_table_t table_at_reset();
        arp_table_t s;
        s          = '0;
        s.timeout  = TIMEOUT_RST;
        s.attempts = ATTEMPTS_RST;
        return s;
    endfunction

    function automatic arp_result_t result_of(input logic [EV_W-1:0] ev,
                                              input logic [ST_W-1:0] st,
                                              input logic [IP_W-1:0] ip,
                                              input logic [MAC_W-1:0] mac,
                                              input logic [ENTRY_W-1:0] cnt);
        arp_result_t r;
        r.ev   = ev;
        r.st   = st;
        r.ip   = ip;
        r.mac  = mac;
        r.cnt  = cnt;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void reg_write(inout arp_table_t s, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        if (idx == CFG_TIMEOUT)
            s.timeout = d[TO_W-1:0];
        else if (idx == CFG_ATTEMPTS)
            s.attempts = d[ATT_W-1:0];
    endfunction

    function automatic void resolve_step(inout arp_table_t s, input arp_cmd_beat_t c,
                                         output arp_result_t r0, output arp_result_t r1,
                                         output int nr);
        int              hit_at;
        logic [TO_W-1:0] eff_to;
        hit_at = -1;
        nr     = 0;
        r0     = '0;
        r1     = '0;
        eff_to = (s.timeout == '0) ? TO_W'(1) : s.timeout;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (i < s.used && hit_at < 0 && s.ips[i] == c.ip)
                hit_at = i;
        case (c.cmd)
            CMD_UPDATE:
            begin
                nr = 1;
                if (s.used >= TABLE_DEPTH)
                    r0 = result_of(EV_UPDATE, ST_FULL, c.ip, '0, s.used);
                else if (hit_at >= 0)
                    r0 = result_of(EV_UPDATE, ST_PRESENT, c.ip, '0, s.used);
                else
                begin
                    s.ips[s.used]  = c.ip;
                    s.macs[s.used] = c.mac;
                    s.used         = s.used + 1'b1;
                    r0 = result_of(EV_UPDATE, ST_OK, c.ip, '0, s.used);
                    if (s.pend && s.pend_ip == c.ip)
                    begin
                        s.pend     = 1'b0;
                        s.att_left = '0;
                        s.wait_cnt = '0;
                        r1 = result_of(EV_LOOKUP, ST_OK, c.ip, c.mac, s.used);
                        nr = 2;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                nr = 1;
                if (hit_at >= 0)
                    r0 = result_of(EV_LOOKUP, ST_OK, c.ip, s.macs[hit_at], s.used);
                else if (s.pend)
                    r0 = result_of(EV_LOOKUP, ST_BUSY, c.ip, '0, s.used);
                else if (!c.link)
                    r0 = result_of(EV_LOOKUP, ST_LINKDOWN, c.ip, '0, s.used);
                else
                begin
                    s.pend     = 1'b1;
                    s.pend_ip  = c.ip;
                    s.att_left = (s.attempts == '0) ? '0 : s.attempts - 1'b1;
                    s.wait_cnt = eff_to;
                    r0 = result_of(EV_REQUEST, ST_NONE, c.ip, '0, s.used);
                end
            end
            CMD_TICK:
            begin
                if (s.pend)
                begin
                    if (s.wait_cnt != '0)
                        s.wait_cnt = s.wait_cnt - 1'b1;
                    if (s.wait_cnt == '0)
                    begin
                        nr = 1;
                        if (s.att_left != '0)
                        begin
                            s.att_left = s.att_left - 1'b1;
                            s.wait_cnt = eff_to;
                            r0 = result_of(EV_REQUEST, ST_NONE, s.pend_ip, '0, s.used);
                        end
                        else
                        begin
                            s.pend = 1'b0;
                            r0 = result_of(EV_LOOKUP, ST_NOREPLY, s.pend_ip, '0, s.used);
                        end
                    end
                end
            end
            default:
                nr = 0;
        endcase
        if (nr == 1)
            r0.last = 1'b1;
        else if (nr == 2)
            r1.last = 1'b1;
    endfunction

    // input side: offers queued commands, predicts results on each accepted beat
    always @(posedge clk)
    begin : drive_cmds
        arp_result_t r0;
        arp_result_t r1;
        int          nr;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                resolve_step(mirror, cur_cmd, r0, r1, nr);
                if (nr > 0)
                    due_results.push_back(r0);
                if (nr > 1)
                    due_results.push_back(r1);
                n_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (cmd_backlog.size() != 0
                    && ((n_taken >= 700 && n_taken < 1000) || $urandom_range(99) >= 34))
                begin
                    cur_cmd = cmd_backlog.pop_front();
                    command  <= cur_cmd.cmd;
                    in_ip    <= cur_cmd.ip;
                    in_mac   <= cur_cmd.mac;
                    link_up  <= cur_cmd.link;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: random stall, one long hold-off, compare with oldest prediction
    always @(posedge clk)
    begin : check_results
        arp_result_t got;
        arp_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.ev   = event_res;
                got.st   = status;
                got.ip   = out_ip;
                got.mac  = out_mac;
                got.cnt  = entry_count;
                got.last = last;
                if (due_results.size() == 0)
                begin
                    if (n_err < 10)
                        $display("unexpected beat: ev=%0d st=%0d ip=%h mac=%h cnt=%0d last=%0b",
                                 got.ev, got.st, got.ip, got.mac, got.cnt, got.last);
                    n_err++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.ev !== want.ev || got.st !== want.st || got.ip !== want.ip
                        || got.mac !== want.mac || got.cnt !== want.cnt
                        || got.last !== want.last)
                    begin
                        if (n_err < 10)
                        begin
                            $display("mismatch: exp ev=%0d st=%0d ip=%h mac=%h cnt=%0d last=%0b",
                                     want.ev, want.st, want.ip, want.mac, want.cnt, want.last);
                            $display("          got ev=%0d st=%0d ip=%h mac=%h cnt=%0d last=%0b",
                                     got.ev, got.st, got.ip, got.mac, got.cnt, got.last);
                        end
                        n_err++;
                    end
                end
                n_results++;
            end
            if (!held && n_results >= 300)
            begin
                held      = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !(n_results >= 800 && n_results < 1100)
                             && ($urandom_range(99) < 34);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_item(input logic [CMD_W-1:0] c, input logic [IP_W-1:0] ip,
                            input logic [MAC_W-1:0] mac, input logic lk);
        arp_cmd_beat_t it;
        arp_result_t   d0;
        arp_result_t   d1;
        int            dn;
        it.cmd  = c;
        it.ip   = ip;
        it.mac  = mac;
        it.link = lk;
        resolve_step(plan, it, d0, d1, dn);
        cmd_backlog.push_back(it);
        n_pushed++;
    endtask

    task automatic wait_idle();
        while (n_taken != n_pushed || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_write(mirror, idx, d);
        reg_write(plan, idx, d);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [IP_W-1:0] known_ip();
        if (plan.used == '0)
            return $urandom;
        return plan.ips[$urandom_range(int'(plan.used) - 1)];
    endfunction

    // mostly lookup / timeout / resolve sequences, appends rationed so the table fills late
    task automatic run_random(input int n_items, input int budget);
        int               r;
        int               left;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        left = budget;
        for (int k = 0; k < n_items; k++)
        begin
            r   = $urandom_range(99);
            mac = MAC_W'({$urandom, $urandom});
            if (r < 3)
                add_item(CMD_UNKNOWN, $urandom, mac, 1'($urandom_range(1)));
            else if (plan.pend)
            begin
                if (r < 50)
                    add_item(CMD_TICK, $urandom, mac, 1'($urandom_range(1)));
                else if (r < 70 && left > 0 && plan.used < TABLE_DEPTH)
                begin
                    add_item(CMD_UPDATE, plan.pend_ip, mac, 1'($urandom_range(1)));
                    left--;
                end
                else if (r < 88)
                begin
                    ip = $urandom_range(1) ? known_ip() : $urandom;
                    add_item(CMD_LOOKUP, ip, mac, 1'($urandom_range(1)));
                end
                else
                    add_item(CMD_UPDATE, known_ip(), mac, 1'($urandom_range(1)));
            end
            else if (r < 55)
            begin
                ip = $urandom_range(1) ? known_ip() : $urandom;
                add_item(CMD_LOOKUP, ip, mac, $urandom_range(99) < 80);
            end
            else if (r < 80)
            begin
                if (left > 0 && $urandom_range(1))
                begin
                    add_item(CMD_UPDATE, $urandom, mac, 1'($urandom_range(1)));
                    left--;
                end
                else
                    add_item(CMD_UPDATE, known_ip(), mac, 1'($urandom_range(1)));
            end
            else
                add_item(CMD_TICK, $urandom, mac, 1'($urandom_range(1)));
        end
        // a lookup stuck behind a long timeout is released before the next setting
        if (plan.pend && plan.wait_cnt > 64 && plan.used < TABLE_DEPTH)
            add_item(CMD_UPDATE, plan.pend_ip, MAC_W'({$urandom, $urandom}), 1'b1);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] to_val;
        logic [CFG_DATA_W-1:0] att_val;
        mirror = table_at_reset();
        plan   = table_at_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, ip zero is an ordinary address
        add_item(CMD_LOOKUP, 32'h0, 48'h0, 1'b0);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b1);
        add_item(CMD_UNKNOWN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_item(CMD_UPDATE, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b0);
        add_item(CMD_LOOKUP, 32'h0, 48'h0, 1'b1);
        add_item(CMD_UPDATE, 32'h0, 48'h0, 1'b1);
        // pending lookup: busy on miss, hit still answers, resolved by append
        add_item(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1);
        add_item(CMD_LOOKUP, 32'h1234_5678, 48'h0, 1'b0);
        add_item(CMD_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b0);
        add_item(CMD_UPDATE, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 1'b1);
        wait_idle();
        // zero registers behave as one
        set_reg(CFG_TIMEOUT, 20'h0);
        set_reg(CFG_ATTEMPTS, 20'h0);
        add_item(CMD_LOOKUP, 32'h0A00_0001, 48'h0, 1'b1);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b0);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b1);
        wait_idle();
        set_reg(CFG_TIMEOUT, 20'h2);
        set_reg(CFG_ATTEMPTS, 20'hFFFFA);
        add_item(CMD_LOOKUP, 32'h0A00_0002, 48'h0, 1'b1);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b0);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b1);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b0);
        add_item(CMD_TICK, 32'h0, 48'h0, 1'b1);
        wait_idle();
        set_reg(CFG_UNUSED_A, 20'hFFFFF);
        set_reg(CFG_UNUSED_B, 20'h0);
        add_item(CMD_UPDATE, 32'h0000_0001, 48'h0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    to_val  = 20'd3;
                    att_val = 20'd3;
                end
                1:
                begin
                    to_val  = 20'hFFFFF;
                    att_val = 20'd7;
                end
                2:
                begin
                    to_val  = 20'd1;
                    att_val = 20'd1;
                end
                3:
                begin
                    to_val  = 20'd2;
                    att_val = 20'hFFFFF;
                end
                4:
                begin
                    to_val  = 20'd0;
                    att_val = 20'd0;
                end
                5:
                begin
                    to_val  = 20'd1;
                    att_val = 20'd7;
                end
                default:
                begin
                    to_val  = CFG_DATA_W'($urandom_range(6));
                    att_val = CFG_DATA_W'($urandom);
                end
            endcase
            wait_idle();
            set_reg(CFG_TIMEOUT, to_val);
            set_reg(CFG_ATTEMPTS, att_val);
            run_random(PHASE_ITEMS, (p < 10) ? 3 : 6);
        end

        wait_idle();
        if (n_err == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
